/* sv/fbpa_pkg.sv */
// shared constants and request/response types for the block pool allocator
// no dependencies; imported by fbpa_pool and fixed_block_pool_allocator_core
package fbpa_pkg;

  // pool geometry
  localparam int MAX_BLOCKS        = 32;
  localparam int BLOCKS_PER_REGION = 8;
  localparam int NUM_REGIONS       = MAX_BLOCKS / BLOCKS_PER_REGION;
  localparam int BLK_W             = $clog2(MAX_BLOCKS);
  localparam int CNT_W             = $clog2(MAX_BLOCKS + 1);
  localparam int OFS_W             = $clog2(BLOCKS_PER_REGION);
  localparam int REGION_W          = BLK_W - OFS_W;
  localparam int CFG_W             = 6;

  localparam logic [CFG_W-1:0] NUM_BLOCKS_RESET = CFG_W'(MAX_BLOCKS);

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [BLK_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic                         ok;
    logic [BLK_W-1:0]             result_block;
    logic [CNT_W-1:0]             free_left;
    logic [REGION_W-1:0]          region_index;
    logic [BLOCKS_PER_REGION-1:0] subregion_mask;
  } rsp_t;

endpackage

/* sv/fixed_block_pool_allocator_core.sv */
// fixed-size block pool allocator: input register, pool update, result register
// depends on fbpa_pkg and fbpa_pool
// a request is taken into the input register, then into the result register, which drives out_valid;
// throughput one request per cycle unless out_ready stalls, with the pool update between the two registers
// reset (synchronous, rst_n low): 32 blocks, head at block zero, links in order,
// all region masks cleared; a config write re-initializes the pool the same way with the written count
module fixed_block_pool_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fbpa_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fbpa_pkg::rsp_t             out_data,
  input  logic                       cfg_we,
  input  logic [fbpa_pkg::CFG_W-1:0] cfg_wdata
);
  import fbpa_pkg::*;

  req_t in_r;
  logic in_valid_r;
  rsp_t out_r;
  logic out_valid_r;
  rsp_t rsp;
  logic advance;

  // request moves into the result register when that register frees up
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // pool state and update logic
  fbpa_pool u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .req       (in_r),
    .rsp       (rsp)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/fbpa_pool.sv */
// free list state, region masks and the per-request update logic
// depends on fbpa_pkg
module fbpa_pool (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [fbpa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      step,
  input  fbpa_pkg::req_t            req,
  output fbpa_pkg::rsp_t            rsp
);
  import fbpa_pkg::*;

  logic [CFG_W-1:0]             num_blocks_r;
  logic [BLK_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             free_count_r, free_count_nxt;
  logic [BLK_W-1:0]             next_link_r [MAX_BLOCKS];
  logic [BLOCKS_PER_REGION-1:0] region_masks_r [NUM_REGIONS];

  logic [CNT_W-1:0]             used_cfg, used_cur;
  logic [BLK_W-1:0]             blk;
  logic [REGION_W-1:0]          region;
  logic [BLOCKS_PER_REGION-1:0] bit_sel, mask_nxt;
  logic                         do_alloc, do_free;

  // clamp the block count to the pool size
  assign used_cfg = (cfg_wdata > CFG_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(cfg_wdata);
  assign used_cur = (num_blocks_r > CFG_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(num_blocks_r);

  // request decode and update
  always_comb begin
    do_alloc       = 1'b0;
    do_free        = 1'b0;
    blk            = '0;
    head_nxt       = head_r;
    free_count_nxt = free_count_r;
    if (req.req_type == REQ_ALLOC) begin
      if (free_count_r != '0) begin
        do_alloc       = 1'b1;
        blk            = head_r;
        head_nxt       = next_link_r[head_r];
        free_count_nxt = free_count_r - CNT_W'(1);
      end
    end else begin
      blk = req.block_index;
      if (free_count_r < used_cur) begin
        do_free        = 1'b1;
        head_nxt       = req.block_index;
        free_count_nxt = free_count_r + CNT_W'(1);
      end
    end
    region  = blk[BLK_W-1:OFS_W];
    bit_sel = BLOCKS_PER_REGION'(1) << blk[OFS_W-1:0];
    if (do_alloc) begin
      mask_nxt = region_masks_r[region] | bit_sel;
    end else if (do_free) begin
      mask_nxt = region_masks_r[region] & ~bit_sel;
    end else if (req.req_type == REQ_FREE) begin
      mask_nxt = region_masks_r[region];
    end else begin
      mask_nxt = '0;
    end
  end

  // response fields
  assign rsp.ok             = do_alloc | do_free;
  assign rsp.result_block   = blk;
  assign rsp.free_left      = free_count_nxt;
  assign rsp.region_index   = region;
  assign rsp.subregion_mask = mask_nxt;

  // pool state, re-initialized by reset and by a config write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      num_blocks_r <= rst_n ? cfg_wdata : NUM_BLOCKS_RESET;
      free_count_r <= rst_n ? used_cfg : CNT_W'(MAX_BLOCKS);
      head_r       <= '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        next_link_r[i] <= BLK_W'(i + 1);
      end
      for (int r = 0; r < NUM_REGIONS; r++) begin
        region_masks_r[r] <= '0;
      end
    end else if (step) begin
      head_r       <= head_nxt;
      free_count_r <= free_count_nxt;
      if (do_free) begin
        next_link_r[req.block_index] <= head_r;
      end
      region_masks_r[region] <= (do_alloc | do_free) ? mask_nxt : region_masks_r[region];
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for fixed_block_pool_allocator_core: a clocked driver and monitor
// compared against a free-list predictor; depends on fbpa_pkg and the core rtl
module testbench;
  import fbpa_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PRINT_CAP   = 40;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  req_t             in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  rsp_t             out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fixed_block_pool_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state: linked free list, count and region write masks
  logic [CFG_W-1:0]             pool_size;
  logic [CNT_W-1:0]             pool_head;
  logic [CNT_W-1:0]             pool_link [MAX_BLOCKS];
  logic [CNT_W-1:0]             pool_avail;
  logic [BLOCKS_PER_REGION-1:0] pool_masks [NUM_REGIONS];

  req_t req_backlog [$];
  rsp_t pool_outcomes [$];
  rsp_t predicted;
  rsp_t wanted;

  int  n_queued     = 0;
  int  n_accepted   = 0;
  int  n_checked    = 0;
  int  n_errors     = 0;
  int  n_sizes      = 1;
  int  n_alloc_ok   = 0;
  int  n_alloc_dry  = 0;
  int  n_free_ok    = 0;
  int  n_free_full  = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  int  quiet_cycles = 0;
  bit  calm         = 1'b0;

  function automatic int pool_cap();
    return (pool_size > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_size);
  endfunction

  // pool state as after reset or a size write
  function automatic void pool_reset(logic [CFG_W-1:0] size_val);
    pool_size = size_val;
    pool_head = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) pool_link[i] = CNT_W'(i + 1);
    for (int r = 0; r < NUM_REGIONS; r++) pool_masks[r] = '0;
    pool_avail = CNT_W'(pool_cap());
  endfunction

  // apply one request to the predicted pool and return the response it yields
  function automatic rsp_t pool_apply(req_t r);
    rsp_t                res;
    logic [BLK_W-1:0]    blk;
    logic [REGION_W-1:0] rgn;
    logic [OFS_W-1:0]    ofs;
    res = '0;
    if (r.req_type == REQ_ALLOC) begin
      if (pool_avail != '0) begin
        // head beyond the pool wraps to its low bits
        blk = pool_head[BLK_W-1:0];
        rgn = blk[BLK_W-1:OFS_W];
        ofs = blk[OFS_W-1:0];
        pool_head = pool_link[blk];
        pool_avail = pool_avail - CNT_W'(1);
        pool_masks[rgn][ofs] = 1'b1;
        res.ok = 1'b1;
        res.result_block = blk;
        res.region_index = rgn;
        res.subregion_mask = pool_masks[rgn];
      end
    end else begin
      blk = r.block_index;
      rgn = blk[BLK_W-1:OFS_W];
      ofs = blk[OFS_W-1:0];
      // no double-free check: the block is pushed whatever its state
      if (int'(pool_avail) < pool_cap()) begin
        pool_link[blk] = pool_head;
        pool_head = CNT_W'(blk);
        pool_avail = pool_avail + CNT_W'(1);
        pool_masks[rgn][ofs] = 1'b0;
        res.ok = 1'b1;
      end
      res.result_block = blk;
      res.region_index = rgn;
      res.subregion_mask = pool_masks[rgn];
    end
    res.free_left = pool_avail;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < PRINT_CAP)
      $display("[%0t] mismatch on response %0d: %s got %0d want %0d",
               $realtime, n_checked, what, got, want);
    n_errors++;
  endtask

  task automatic queue_req(logic kind, logic [BLK_W-1:0] blk);
    req_t r;
    r.req_type = kind;
    r.block_index = blk;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // wait until every request is accepted and every response is checked
  task automatic wait_drained();
    while (n_accepted != n_queued || pool_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_pool_size(logic [CFG_W-1:0] size_val);
    wait_drained();
    cfg_wdata <= size_val;
    cfg_we <= 1'b1;
    pool_reset(size_val);
    n_sizes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: mostly allocs and frees of held blocks, with stray frees mixed in;
  // a plain stack of free blocks steers the frees toward blocks really in use
  task automatic queue_random_phase(int count);
    int               free_stack [$];
    int               held [$];
    int               cap;
    int               alloc_pct;
    int               roll;
    int               idx;
    logic             kind;
    logic [BLK_W-1:0] blk;
    cap = pool_cap();
    alloc_pct = 50;
    for (int i = 0; i < cap; i++) free_stack.push_back(i);
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 25;
          1: alloc_pct = 50;
          default: alloc_pct = 80;
        endcase
      end
      roll = $urandom_range(0, 99);
      blk = '0;
      if (roll < 12) begin
        // stray free: any block, possibly already free or outside the pool
        kind = REQ_FREE;
        blk = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
      end else if (held.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        kind = REQ_ALLOC;
        blk = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
      end else begin
        kind = REQ_FREE;
        idx = $urandom_range(0, held.size() - 1);
        blk = BLK_W'(held[idx]);
      end
      if (kind == REQ_ALLOC) begin
        if (free_stack.size() > 0) held.push_back(free_stack.pop_front());
      end else if (free_stack.size() < cap) begin
        free_stack.push_front(int'(blk));
        for (int k = 0; k < held.size(); k++) begin
          if (held[k] == int'(blk)) begin
            held.delete(k);
            break;
          end
        end
      end
      queue_req(kind, blk);
    end
  endtask

  // request driver: predicts each accepted request, then loads the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = pool_apply(in_data);
        pool_outcomes.push_back(predicted);
        if (in_data.req_type == REQ_ALLOC) begin
          if (predicted.ok) n_alloc_ok++;
          else n_alloc_dry++;
        end else begin
          if (predicted.ok) n_free_ok++;
          else n_free_full++;
        end
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_data <= req_backlog.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: checks against the oldest prediction, then sets ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pool_outcomes.size() == 0) begin
          report_mismatch("response with no request pending, block",
                          out_data.result_block, -1);
        end else begin
          wanted = pool_outcomes.pop_front();
          if (out_data.ok !== wanted.ok)
            report_mismatch("ok", out_data.ok, wanted.ok);
          if (out_data.result_block !== wanted.result_block)
            report_mismatch("result_block", out_data.result_block, wanted.result_block);
          if (out_data.free_left !== wanted.free_left)
            report_mismatch("free_left", out_data.free_left, wanted.free_left);
          if (out_data.region_index !== wanted.region_index)
            report_mismatch("region_index", out_data.region_index, wanted.region_index);
          if (out_data.subregion_mask !== wanted.subregion_mask)
            report_mismatch("subregion_mask", out_data.subregion_mask,
                            wanted.subregion_mask);
        end
        n_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 16);
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    int sizes [$];
    pool_reset(NUM_BLOCKS_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // full pool at reset size: frees are refused until allocs make room
    queue_req(REQ_FREE, BLK_W'(MAX_BLOCKS - 1));
    queue_req(REQ_FREE, '0);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '1);
    queue_req(REQ_FREE, BLK_W'(1));
    // double free turns the head into a self loop
    queue_req(REQ_FREE, BLK_W'(1));
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, BLK_W'(16));
    queue_req(REQ_ALLOC, '0);

    // single block: empty and full in turn
    set_pool_size(CFG_W'(1));
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_ALLOC, '1);
    queue_req(REQ_FREE, '0);
    queue_req(REQ_FREE, '0);
    queue_req(REQ_FREE, BLK_W'(MAX_BLOCKS - 1));

    // zero blocks: always empty and always full
    set_pool_size(CFG_W'(0));
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, BLK_W'(5));

    // oversized count acts as the full pool
    set_pool_size('1);
    queue_req(REQ_FREE, BLK_W'(7));
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, BLK_W'(24));

    // random phases over a spread of pool sizes, the last without idling
    sizes = '{8, 32, 1, 40, 3, 24};
    sizes.push_back($urandom_range(2, 31));
    sizes.push_back($urandom_range(33, 63));
    sizes.push_back(MAX_BLOCKS);
    foreach (sizes[p]) begin
      set_pool_size(CFG_W'(sizes[p]));
      if (p == sizes.size() - 1) calm = 1'b1;
      queue_random_phase(60);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("checked %0d requests over %0d pool sizes", n_checked, n_sizes);
    $display("allocs: %0d granted, %0d on empty pool; frees: %0d taken, %0d on full pool",
             n_alloc_ok, n_alloc_dry, n_free_ok, n_free_full);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
